// File: hdl/itl_pkg.sv
// Shared types and constants for the IP transport header locator.
// No dependencies; imported by every module of the block.
package itl_pkg;

  // Byte counter width; the counter saturates at its all-ones value.
  localparam int CNT_BITS = 16;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  localparam int OUT_W = 16;

  // Parse phase codes
  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_V4      = 3'd1;
  localparam logic [2:0] PH_V6FIXED = 3'd2;
  localparam logic [2:0] PH_V6WAIT  = 3'd3;
  localparam logic [2:0] PH_V6LEN   = 3'd4;
  localparam logic [2:0] PH_V6FRAG  = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  // Latched outcome codes
  localparam logic [2:0] LT_NONE    = 3'd0;
  localparam logic [2:0] LT_REACHED = 3'd1;
  localparam logic [2:0] LT_NOTIP   = 3'd2;
  localparam logic [2:0] LT_LATER   = 3'd3;
  localparam logic [2:0] LT_TRUNC   = 3'd4;
  localparam logic [2:0] LT_NOTRANS = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_FOUND   = 3'd0;
  localparam logic [2:0] ST_NOTIP   = 3'd1;
  localparam logic [2:0] ST_OTHER   = 3'd2;
  localparam logic [2:0] ST_LATER   = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;
  localparam logic [2:0] ST_NOTRANS = 3'd5;

  // Next-header / protocol numbers
  localparam logic [7:0] NH_HOPOPT  = 8'd0;
  localparam logic [7:0] NH_TCP     = 8'd6;
  localparam logic [7:0] NH_UDP     = 8'd17;
  localparam logic [7:0] NH_ROUTING = 8'd43;
  localparam logic [7:0] NH_FRAG    = 8'd44;
  localparam logic [7:0] NH_ICMP6   = 8'd58;
  localparam logic [7:0] NH_DSTOPT  = 8'd60;

  localparam logic [7:0] WANTED_RESET = NH_TCP;

  localparam logic [3:0] VER_4 = 4'd4;
  localparam logic [3:0] VER_6 = 4'd6;

  localparam int V4_MIN_HDR = 20;
  localparam int V6_FIXED   = 40;
  localparam int FRAG_LEN   = 8;

  // Per-packet summary handed from the parser to the result stage.
  typedef struct packed {
    logic                notip;
    logic                v4;
    logic [2:0]          outcome;
    logic [3:0]          header_words;
    logic [15:0]         total_length;
    logic [12:0]         frag_offset;
    logic [7:0]          cur_nh;
    logic [CNT_BITS-1:0] ext_end;
    logic [CNT_BITS-1:0] cap;
  } itl_rec_t;

  typedef struct packed {
    logic     valid;
    itl_rec_t rec;
  } itl_push_t;

endpackage

// File: hdl/ip_transport_header_locator.sv
// Top level of the IP transport header locator.
// Instantiates itl_front, itl_queue and itl_back; uses itl_pkg.
//
// The block takes an IP packet one byte per item, starting at the IP header,
// with tlast on the final captured byte, and gives one result per packet.
// Bytes are accepted back to back at one per cycle while the queue is not
// full: a byte parser updates a handful of captured header fields on each
// accepted byte, and on the last byte writes a packet summary into a
// two-entry queue. A result stage turns the summary into status, offsets
// and lengths and holds it in the output register, which is loaded from the
// queue head while the output is not stalled. s_axis_tready drops while the
// queue holds two summaries, which only happens when the output is stalled.
// IPv4 and IPv6 (with hop-by-hop, routing, destination-option and fragment
// extension headers) are handled; cfg_wdata, written with cfg_we, sets the
// wanted protocol (reset TCP) and is to be changed only while no packet is in
// flight. The byte counter saturates at 65535.
module ip_transport_header_locator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [10:3] transport_protocol, [11] is_version6,
  // [27:12] transport_offset, [43:28] header_length,
  // [59:44] payload_length, [75:60] effective_end, [79:76] zero
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import itl_pkg::*;

  logic       [7:0] wanted_protocol;
  itl_push_t        push;
  logic             queue_full;
  logic             head_valid;
  itl_rec_t         head;
  logic             pop;
  logic             byte_take;

  logic [2:0]  status;
  logic [7:0]  transport_protocol;
  logic        is_version6;
  logic [15:0] transport_offset;
  logic [15:0] header_length;
  logic [15:0] payload_length;
  logic [15:0] effective_end;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) wanted_protocol <= WANTED_RESET;
    else if (cfg_we) wanted_protocol <= cfg_wdata;
  end

  assign s_axis_tready = !queue_full;
  assign byte_take     = s_axis_tvalid && s_axis_tready;

  itl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_take),
    .byte_data  (s_axis_tdata),
    .byte_last  (s_axis_tlast),
    .push       (push)
  );

  itl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  itl_back u_back (
    .clk                (clk),
    .rst                (rst),
    .wanted_protocol    (wanted_protocol),
    .head_valid         (head_valid),
    .head               (head),
    .pop                (pop),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .status             (status),
    .transport_protocol (transport_protocol),
    .is_version6        (is_version6),
    .transport_offset   (transport_offset),
    .header_length      (header_length),
    .payload_length     (payload_length),
    .effective_end      (effective_end)
  );

  assign m_axis_tdata = {4'b0000, effective_end, payload_length, header_length,
                         transport_offset, is_version6, transport_protocol, status};

  // Queue must never be written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !queue_full)
    else $error("summary pushed into full queue");

  // A not-IP result carries no header info.
  a_notip_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status == ST_NOTIP) |-> (header_length == 16'd0 && !is_version6))
    else $error("not-IP result with header fields");

  // Status codes above no-transport never appear.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (status <= ST_NOTRANS))
    else $error("bad status code");

  // A result leaves the queue only when the output register can take it.
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    pop |-> (head_valid && (!m_axis_tvalid || m_axis_tready)))
    else $error("pop without room");

endmodule

// File: hdl/itl_front.sv
// Byte parser: walks IPv4/IPv6 headers one byte per cycle while byte_valid is
// high and emits a per-packet summary on the last byte. Depends on itl_pkg.
module itl_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  logic [7:0]       byte_data,
  input  logic             byte_last,
  output itl_pkg::itl_push_t push
);
  import itl_pkg::*;

  logic [2:0]          phase, phase_next;
  logic [CNT_BITS-1:0] byte_position, byte_position_next;
  logic [7:0]          cur_nh, cur_nh_next;
  logic [CNT_BITS-1:0] ext_end, ext_end_next;
  logic [15:0]         total_length, total_length_next;
  logic [12:0]         frag_offset, frag_offset_next;
  logic [3:0]          header_words, header_words_next;
  logic [2:0]          outcome, outcome_next;

  logic [CNT_BITS+1:0] len_end;
  logic [CNT_BITS:0]   frag_end;
  logic [CNT_BITS-1:0] ext_m6, ext_m5;

  assign len_end  = (CNT_BITS+2)'(byte_position) + (CNT_BITS+2)'(7)
                  + (CNT_BITS+2)'({byte_data, 3'b000});
  assign frag_end = (CNT_BITS+1)'(byte_position) + (CNT_BITS+1)'(FRAG_LEN);
  assign ext_m6   = ext_end - CNT_BITS'(6);
  assign ext_m5   = ext_end - CNT_BITS'(5);

  always_comb begin
    phase_next        = phase;
    cur_nh_next       = cur_nh;
    ext_end_next      = ext_end;
    total_length_next = total_length;
    frag_offset_next  = frag_offset;
    header_words_next = header_words;
    outcome_next      = outcome;
    byte_position_next = (byte_position != CNT_MAX) ? byte_position + CNT_BITS'(1)
                                                    : byte_position;

    unique case (phase)
      PH_VERSION: begin
        if (byte_data[7:4] == VER_4) begin
          header_words_next = byte_data[3:0];
          phase_next        = PH_V4;
        end else if (byte_data[7:4] == VER_6) begin
          phase_next = PH_V6FIXED;
        end else begin
          outcome_next = LT_NOTIP;
          phase_next   = PH_DONE;
        end
      end
      PH_V4: begin
        if (byte_position == CNT_BITS'(2))
          total_length_next = {byte_data, total_length[7:0]};
        else if (byte_position == CNT_BITS'(3))
          total_length_next = {total_length[15:8], byte_data};
        else if (byte_position == CNT_BITS'(6))
          frag_offset_next = {byte_data[4:0], frag_offset[7:0]};
        else if (byte_position == CNT_BITS'(7))
          frag_offset_next = {frag_offset[12:8], byte_data};
        else if (byte_position == CNT_BITS'(9))
          cur_nh_next = byte_data;
      end
      PH_V6FIXED: begin
        if (byte_position == CNT_BITS'(4))
          total_length_next = {byte_data, total_length[7:0]};
        else if (byte_position == CNT_BITS'(5))
          total_length_next = {total_length[15:8], byte_data};
        else if (byte_position == CNT_BITS'(6))
          cur_nh_next = byte_data;
        else if (byte_position == CNT_BITS'(V6_FIXED - 1)) begin
          ext_end_next = CNT_BITS'(V6_FIXED);
          phase_next   = PH_V6WAIT;
        end
      end
      PH_V6WAIT: begin
        if (byte_position == ext_end) begin
          case (cur_nh) inside
            NH_TCP, NH_UDP, NH_ICMP6: begin
              outcome_next = LT_REACHED;
              phase_next   = PH_DONE;
            end
            NH_HOPOPT, NH_ROUTING, NH_DSTOPT: begin
              cur_nh_next = byte_data;
              phase_next  = PH_V6LEN;
            end
            NH_FRAG: begin
              cur_nh_next      = byte_data;
              frag_offset_next = '0;
              if (frag_end >= (CNT_BITS+1)'(CNT_MAX)) begin
                outcome_next = LT_TRUNC;
                phase_next   = PH_DONE;
              end else begin
                ext_end_next = frag_end[CNT_BITS-1:0];
                phase_next   = PH_V6FRAG;
              end
            end
            default: begin
              outcome_next = LT_NOTRANS;
              phase_next   = PH_DONE;
            end
          endcase
        end
      end
      PH_V6LEN: begin
        if (len_end >= (CNT_BITS+2)'(CNT_MAX)) begin
          outcome_next = LT_TRUNC;
          phase_next   = PH_DONE;
        end else begin
          ext_end_next = len_end[CNT_BITS-1:0];
          phase_next   = PH_V6WAIT;
        end
      end
      PH_V6FRAG: begin
        if (byte_position == ext_m6) begin
          frag_offset_next = {byte_data, 5'b00000};
        end else if (byte_position == ext_m5) begin
          frag_offset_next = {frag_offset[12:5], frag_offset[4:0] | byte_data[7:3]};
          if ({frag_offset[12:5], frag_offset[4:0] | byte_data[7:3]} != 13'd0) begin
            outcome_next = LT_LATER;
            phase_next   = PH_DONE;
          end else begin
            phase_next = PH_V6WAIT;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    push.valid            = byte_valid && byte_last;
    push.rec.notip        = (outcome_next == LT_NOTIP);
    push.rec.v4           = (phase_next == PH_V4);
    push.rec.outcome      = outcome_next;
    push.rec.header_words = header_words_next;
    push.rec.total_length = total_length_next;
    push.rec.frag_offset  = frag_offset_next;
    push.rec.cur_nh       = cur_nh_next;
    push.rec.ext_end      = ext_end_next;
    push.rec.cap          = byte_position_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_valid && byte_last)) begin
      phase         <= PH_VERSION;
      byte_position <= '0;
      cur_nh        <= '0;
      ext_end       <= '0;
      total_length  <= '0;
      frag_offset   <= '0;
      header_words  <= '0;
      outcome       <= LT_NONE;
    end else if (byte_valid) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      cur_nh        <= cur_nh_next;
      ext_end       <= ext_end_next;
      total_length  <= total_length_next;
      frag_offset   <= frag_offset_next;
      header_words  <= header_words_next;
      outcome       <= outcome_next;
    end
  end

endmodule

// File: hdl/itl_queue.sv
// Two-entry queue of packet summaries between parser and result stage.
// Depends on itl_pkg.
module itl_queue (
  input  logic               clk,
  input  logic               rst,
  input  itl_pkg::itl_push_t push,
  output logic               full,
  output logic               head_valid,
  output itl_pkg::itl_rec_t  head,
  input  logic               pop
);
  import itl_pkg::*;

  itl_rec_t   entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) entry[wr_ptr] <= push.rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/itl_back.sv
// Result stage: turns a packet summary into status, offsets and lengths
// and holds it in the output register. Depends on itl_pkg.
module itl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        wanted_protocol,
  input  logic              head_valid,
  input  itl_pkg::itl_rec_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [7:0]        transport_protocol,
  output logic              is_version6,
  output logic [15:0]       transport_offset,
  output logic [15:0]       header_length,
  output logic [15:0]       payload_length,
  output logic [15:0]       effective_end
);
  import itl_pkg::*;

  logic [2:0]  st;
  logic [7:0]  proto;
  logic        v6;
  logic [15:0] toff, hlen, pay, eend;
  logic [15:0] cap16, ext16, hlen4;

  assign cap16 = OUT_W'(head.cap);
  assign ext16 = OUT_W'(head.ext_end);
  assign hlen4 = {10'd0, head.header_words, 2'b00};
  assign pop   = head_valid && (!out_valid || out_ready);

  always_comb begin
    st    = ST_TRUNC;
    proto = '0;
    v6    = 1'b0;
    toff  = '0;
    hlen  = '0;
    pay   = '0;
    eend  = cap16;
    if (head.notip) begin
      st = ST_NOTIP;
    end else if (head.v4) begin
      hlen  = hlen4;
      toff  = hlen4;
      proto = head.cur_nh;
      pay   = (head.total_length >= hlen4) ? head.total_length - hlen4 : '0;
      if (head.total_length < cap16) eend = head.total_length;
      if (cap16 < 16'(V4_MIN_HDR) || cap16 < hlen4) st = ST_TRUNC;
      else if (proto != wanted_protocol)             st = ST_OTHER;
      else if (head.frag_offset != 13'd0)             st = ST_LATER;
      else                                            st = ST_FOUND;
    end else begin
      v6    = 1'b1;
      proto = head.cur_nh;
      pay   = head.total_length;
      case (head.outcome)
        LT_REACHED: begin
          st   = (proto == wanted_protocol) ? ST_FOUND : ST_OTHER;
          toff = ext16;
          hlen = ext16;
        end
        LT_NOTRANS: begin
          st   = ST_NOTRANS;
          toff = ext16;
          hlen = ext16;
        end
        LT_LATER: st = ST_LATER;
        default:  st = ST_TRUNC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status             <= st;
      transport_protocol <= proto;
      is_version6        <= v6;
      transport_offset   <= toff;
      header_length      <= hlen;
      payload_length     <= pay;
      effective_end      <= eend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pop) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule

// File: test/tb_top.sv
// Self-checking bench for ip_transport_header_locator: packets go in as byte items on the
// input stream and summaries are compared with an in-bench locator model.
// Depends on itl_pkg (hdl/itl_pkg.sv) and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itl_pkg::*;

  localparam logic [7:0] NH_NONE = 8'd59;    // IPv6 "no next header"
  localparam int HOLD_AT         = 4;        // result count that starts the long stall
  localparam int HOLD_CYCLES     = 500;
  localparam int PHASE_BYTES     = 130;
  localparam int PHASE_PACKETS   = 2;
  localparam int RANDOM_PHASES   = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // Same layout as m_axis_tdata, msb first.
  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] eend;
    logic [15:0] pay;
    logic [15:0] hlen;
    logic [15:0] toff;
    logic        v6;
    logic [7:0]  proto;
    logic [2:0]  status;
  } summary_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  ip_transport_header_locator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Locator model state (one packet in flight) and the wanted protocol copy
  // ---------------------------------------------------------------------------
  logic [2:0]  loc_phase    = PH_VERSION;
  logic [15:0] byte_count   = '0;
  logic [7:0]  cur_next_hdr = '0;
  logic [15:0] ext_end      = '0;
  logic [15:0] total_len    = '0;
  logic [12:0] frag_off     = '0;
  logic [3:0]  hdr_words    = '0;
  logic [2:0]  outcome      = LT_NONE;
  logic [7:0]  wanted_proto = WANTED_RESET;

  summary_t   expected_summaries[$];
  byte_item_t byte_queue[$];
  logic [7:0] pkt[$];            // packet under construction
  int unsigned bytes_queued = 0;
  int unsigned packets_queued = 0;
  int unsigned errors = 0;

  task automatic clear_packet_state();
    loc_phase    = PH_VERSION;
    byte_count   = '0;
    cur_next_hdr = '0;
    ext_end      = '0;
    total_len    = '0;
    frag_off     = '0;
    hdr_words    = '0;
    outcome      = LT_NONE;
  endtask

  task automatic decide(input logic [2:0] code);
    outcome   = code;
    loc_phase = PH_DONE;
  endtask

  // One accepted byte; on the last byte the summary goes to the expected queue.
  task automatic locate_step(input logic [7:0] b, input logic last);
    int unsigned pos;
    int unsigned e;
    int unsigned hl;
    summary_t    res;
    pos = byte_count;
    if (byte_count != CNT_MAX) byte_count = byte_count + 16'd1;

    case (loc_phase)
      PH_VERSION: begin
        if (b[7:4] == VER_4) begin
          hdr_words = b[3:0];
          loc_phase = PH_V4;
        end else if (b[7:4] == VER_6) begin
          loc_phase = PH_V6FIXED;
        end else begin
          decide(LT_NOTIP);
        end
      end
      PH_V4: begin
        case (pos)
          2: total_len[15:8] = b;
          3: total_len[7:0] = b;
          6: frag_off[12:8] = b[4:0];
          7: frag_off[7:0] = b;
          9: cur_next_hdr = b;
          default: ;
        endcase
      end
      PH_V6FIXED: begin
        case (pos)
          4: total_len[15:8] = b;
          5: total_len[7:0] = b;
          6: cur_next_hdr = b;
          39: begin
            ext_end   = 16'(V6_FIXED);
            loc_phase = PH_V6WAIT;
          end
          default: ;
        endcase
      end
      PH_V6WAIT: begin
        if (pos == ext_end) begin
          case (cur_next_hdr)
            NH_TCP, NH_UDP, NH_ICMP6: decide(LT_REACHED);
            NH_HOPOPT, NH_ROUTING, NH_DSTOPT: begin
              cur_next_hdr = b;
              loc_phase    = PH_V6LEN;
            end
            NH_FRAG: begin
              cur_next_hdr = b;
              frag_off     = '0;
              if (pos + FRAG_LEN >= CNT_MAX) begin
                decide(LT_TRUNC);
              end else begin
                ext_end   = 16'(pos + FRAG_LEN);
                loc_phase = PH_V6FRAG;
              end
            end
            default: decide(LT_NOTRANS);
          endcase
        end
      end
      PH_V6LEN: begin
        // header length byte: (len+1)*8 bytes from the header start
        e = pos + 7 + b * 8;
        if (e >= CNT_MAX) begin
          decide(LT_TRUNC);
        end else begin
          ext_end   = 16'(e);
          loc_phase = PH_V6WAIT;
        end
      end
      PH_V6FRAG: begin
        if (pos == ext_end - 6) begin
          frag_off = {b, 5'b0};
        end else if (pos == ext_end - 5) begin
          frag_off = frag_off | {8'd0, b[7:3]};
          if (frag_off != '0) decide(LT_LATER);
          else loc_phase = PH_V6WAIT;
        end
      end
      default: ;
    endcase

    if (last) begin
      res      = '0;
      res.eend = byte_count;
      if (outcome == LT_NOTIP) begin
        res.status = ST_NOTIP;
      end else if (loc_phase == PH_V4) begin
        hl        = 4 * hdr_words;
        res.toff  = 16'(hl);
        res.hlen  = 16'(hl);
        res.proto = cur_next_hdr;
        res.pay   = (total_len >= hl) ? 16'(total_len - hl) : '0;
        if (total_len < byte_count) res.eend = total_len;
        if (byte_count < V4_MIN_HDR || byte_count < hl) res.status = ST_TRUNC;
        else if (cur_next_hdr != wanted_proto) res.status = ST_OTHER;
        else if (frag_off != '0) res.status = ST_LATER;
        else res.status = ST_FOUND;
      end else begin
        res.v6    = 1'b1;
        res.proto = cur_next_hdr;
        res.pay   = total_len;
        case (outcome)
          LT_REACHED: begin
            res.status = (cur_next_hdr == wanted_proto) ? ST_FOUND : ST_OTHER;
            res.toff   = ext_end;
            res.hlen   = ext_end;
          end
          LT_NOTRANS: begin
            res.status = ST_NOTRANS;
            res.toff   = ext_end;
            res.hlen   = ext_end;
          end
          LT_LATER: res.status = ST_LATER;
          default:  res.status = ST_TRUNC;
        endcase
      end
      expected_summaries.push_back(res);
      clear_packet_state();
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= 40)
      $display("%0t ns: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Packet construction
  // ---------------------------------------------------------------------------
  task automatic add_random(input int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  // IPv4 header of max(20, ihl*4) bytes followed by payload_bytes of filler.
  task automatic build_v4(input logic [3:0] ihl, input logic [15:0] total,
                          input logic [12:0] frag, input logic [7:0] proto,
                          input int payload_bytes);
    int hdr;
    hdr = (4 * ihl < V4_MIN_HDR) ? V4_MIN_HDR : 4 * ihl;
    add_random(hdr + payload_bytes);
    pkt[0] = {VER_4, ihl};
    pkt[2] = total[15:8];
    pkt[3] = total[7:0];
    pkt[6] = {3'($urandom_range(0, 7)), frag[12:8]};   // flags are don't care
    pkt[7] = frag[7:0];
    pkt[9] = proto;
  endtask

  task automatic build_v6_fixed(input logic [7:0] nh, input logic [15:0] plen);
    add_random(V6_FIXED);
    pkt[0] = {VER_6, 4'($urandom_range(0, 15))};
    pkt[4] = plen[15:8];
    pkt[5] = plen[7:0];
    pkt[6] = nh;
  endtask

  // Options-style extension header, (len+1)*8 bytes.
  task automatic add_ext(input logic [7:0] nh, input logic [7:0] len);
    pkt.push_back(nh);
    pkt.push_back(len);
    add_random(len * 8 + 6);
  endtask

  task automatic add_frag(input logic [7:0] nh, input logic [12:0] off);
    pkt.push_back(nh);
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(off[12:5]);
    pkt.push_back({off[4:0], 3'($urandom_range(0, 7))});
    add_random(4);
  endtask

  // Hand the packet to the driver, cut to keep bytes (0 = whole packet).
  task automatic queue_packet(input int keep);
    int n;
    byte_item_t it;
    n = (keep <= 0 || keep > pkt.size()) ? pkt.size() : keep;
    for (int i = 0; i < n; i++) begin
      it.data = pkt[i];
      it.last = (i == n - 1);
      byte_queue.push_back(it);
    end
    bytes_queued += n;
    packets_queued++;
    pkt.delete();
  endtask

  function automatic logic [7:0] pick_transport();
    case ($urandom_range(0, 6))
      0: return NH_TCP;
      1: return NH_UDP;
      2: return NH_ICMP6;
      3: return NH_NONE;
      4: return wanted_proto;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_ext();
    case ($urandom_range(0, 3))
      0: return NH_HOPOPT;
      1: return NH_ROUTING;
      2: return NH_DSTOPT;
      default: return NH_FRAG;
    endcase
  endfunction

  task automatic random_packet();
    int unsigned kind;
    logic [3:0]  ihl;
    logic [15:0] total;
    int          pay_bytes;
    logic [7:0]  chain[$];
    int          keep;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // not IP: version nibble anything but 4 and 6
      do ihl = 4'($urandom_range(0, 15)); while (ihl == VER_4 || ihl == VER_6);
      pkt.push_back({ihl, 4'($urandom_range(0, 15))});
      add_random($urandom_range(0, 20));
    end else if (kind < 15) begin
      add_random($urandom_range(1, 30));              // raw noise
    end else if (kind < 50) begin
      ihl       = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 4))
                                              : 4'($urandom_range(5, 15));
      pay_bytes = $urandom_range(0, 40);
      case ($urandom_range(0, 5))
        0: total = 16'($urandom_range(0, 65535));
        1: total = 16'($urandom_range(0, 4 * ihl + pay_bytes));   // padded frame
        default: total = 16'(4 * ihl + pay_bytes);
      endcase
      build_v4(ihl, total,
               ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 8191)) : 13'd0,
               ($urandom_range(0, 1) == 0) ? wanted_proto : pick_transport(),
               pay_bytes);
    end else begin
      repeat ($urandom_range(0, 4)) chain.push_back(pick_ext());
      chain.push_back(pick_transport());
      build_v6_fixed(chain[0], 16'($urandom_range(0, 65535)));
      for (int i = 0; i < chain.size() - 1; i++) begin
        if (chain[i] == NH_FRAG)
          add_frag(chain[i+1],
                   ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 8191)) : 13'd0);
        else
          add_ext(chain[i+1], ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 3)));
      end
      add_random($urandom_range(0, 20));
    end
    keep = ($urandom_range(0, 5) == 0) ? $urandom_range(1, pkt.size()) : 0;
    queue_packet(keep);
  endtask

  // Wait at falling edges, where every update of the edge has settled, until the
  // driver and the block have nothing left, then a few more cycles.
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_queue.size() != 0 || s_axis_tvalid || expected_summaries.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_wanted(input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    wanted_proto = value;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; holds an item until taken
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  byte_item_t  next_item;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      clear_packet_state();
    end else begin
      if (s_axis_tvalid && s_axis_tready) locate_step(s_axis_tdata, s_axis_tlast);

      if (s_axis_tvalid && !s_axis_tready) begin
        // item still waiting: leave it on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        next_item     = byte_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_item.data;
        s_axis_tlast  <= next_item.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // mostly short bursts, now and then a long gap-free run
          burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall pattern by modes, one long hold-off, result checks
  // ---------------------------------------------------------------------------
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  summary_t    got_sum;
  summary_t    want_sum;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_sum = summary_t'(m_axis_tdata);
        results_seen++;
        if (expected_summaries.size() == 0) begin
          report_mismatch("unexpected result, status", got_sum.status, 0);
        end else begin
          want_sum = expected_summaries.pop_front();
          if (got_sum.status != want_sum.status)
            report_mismatch("status", got_sum.status, want_sum.status);
          if (got_sum.proto != want_sum.proto)
            report_mismatch("transport_protocol", got_sum.proto, want_sum.proto);
          if (got_sum.v6 != want_sum.v6)
            report_mismatch("is_version6", got_sum.v6, want_sum.v6);
          if (got_sum.toff != want_sum.toff)
            report_mismatch("transport_offset", got_sum.toff, want_sum.toff);
          if (got_sum.hlen != want_sum.hlen)
            report_mismatch("header_length", got_sum.hlen, want_sum.hlen);
          if (got_sum.pay != want_sum.pay)
            report_mismatch("payload_length", got_sum.pay, want_sum.pay);
          if (got_sum.eend != want_sum.eend)
            report_mismatch("effective_end", got_sum.eend, want_sum.eend);
        end
        // long stall so the summary queue fills and s_axis_tready drops
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end

      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed packets at the reset protocol, then random phases
  // ---------------------------------------------------------------------------
  int unsigned phase_start_bytes;
  int unsigned phase_start_pkts;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // not IP, one byte and several bytes
    pkt.push_back(8'h00);
    queue_packet(0);
    pkt.push_back(8'hFF);
    add_random(5);
    queue_packet(0);
    // IPv4: found, other protocol with long total, later fragment
    build_v4(4'd5, 16'd40, 13'd0, NH_TCP, 20);
    queue_packet(0);
    build_v4(4'd15, 16'hFFFF, 13'd0, NH_UDP, 10);
    queue_packet(0);
    build_v4(4'd5, 16'd60, 13'h1FFF, NH_TCP, 40);
    queue_packet(0);
    // IPv4 truncated: under 20 bytes, single byte, under IHL*4
    build_v4(4'd5, 16'd40, 13'd0, NH_TCP, 20);
    queue_packet(19);
    build_v4(4'd5, 16'd40, 13'd0, NH_TCP, 20);
    queue_packet(1);
    build_v4(4'd15, 16'd80, 13'd0, NH_TCP, 20);
    queue_packet(50);
    // IPv4 IHL zero, total below header, padding past total length
    build_v4(4'd0, 16'd30, 13'd0, NH_TCP, 10);
    queue_packet(0);
    build_v4(4'd5, 16'd10, 13'd0, NH_TCP, 4);
    queue_packet(0);
    build_v4(4'd5, 16'd28, 13'd0, NH_TCP, 20);
    queue_packet(0);
    // IPv6 straight to TCP, UDP, ICMPv6
    build_v6_fixed(NH_TCP, 16'd20);
    add_random(20);
    queue_packet(0);
    build_v6_fixed(NH_UDP, 16'd8);
    add_random(8);
    queue_packet(0);
    build_v6_fixed(NH_ICMP6, 16'd8);
    add_random(8);
    queue_packet(0);
    // hop-by-hop, routing, destination options, then TCP
    build_v6_fixed(NH_HOPOPT, 16'd76);
    add_ext(NH_ROUTING, 8'd0);
    add_ext(NH_DSTOPT, 8'd1);
    add_ext(NH_TCP, 8'd2);
    add_random(20);
    queue_packet(0);
    // first fragment passes, later fragments stop the walk
    build_v6_fixed(NH_FRAG, 16'd28);
    add_frag(NH_TCP, 13'd0);
    add_random(20);
    queue_packet(0);
    build_v6_fixed(NH_FRAG, 16'd16);
    add_frag(NH_UDP, 13'h1FFF);
    add_random(8);
    queue_packet(0);
    build_v6_fixed(NH_DSTOPT, 16'd24);
    add_ext(NH_FRAG, 8'd0);
    add_frag(NH_ICMP6, 13'd1);
    add_random(8);
    queue_packet(0);
    // no transport: directly and after an extension
    build_v6_fixed(NH_NONE, 16'd0);
    add_random(4);
    queue_packet(0);
    build_v6_fixed(NH_ROUTING, 16'hFFFF);
    add_ext(NH_NONE, 8'd0);
    add_random(4);
    queue_packet(0);
    // IPv6 truncated: in fixed header, right at transport start, inside an extension
    build_v6_fixed(NH_TCP, 16'd0);
    queue_packet(20);
    build_v6_fixed(NH_TCP, 16'd0);
    queue_packet(40);
    build_v6_fixed(NH_HOPOPT, 16'd0);
    add_ext(NH_TCP, 8'd3);
    add_random(8);
    queue_packet(50);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_wanted(NH_UDP);
        1: write_wanted(8'd0);
        2: write_wanted(8'hFF);
        3: write_wanted(8'($urandom_range(0, 255)));
        default: write_wanted(NH_ICMP6);
      endcase
      @(negedge clk);
      phase_start_bytes = bytes_queued;
      phase_start_pkts  = packets_queued;
      while (bytes_queued - phase_start_bytes < PHASE_BYTES ||
             packets_queued - phase_start_pkts < PHASE_PACKETS)
        random_packet();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("ip_transport_header_locator regression: pass");
    else
      $display("ip_transport_header_locator regression: fail");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(2_000_000);
    $display("ip_transport_header_locator regression: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/itl_pkg.sv
hdl/itl_front.sv
hdl/itl_queue.sv
hdl/itl_back.sv
hdl/ip_transport_header_locator.sv
test/tb_top.sv
